[hw/rtl/glow_alpha_convolution_5x5_top_assert.svh]
// Assertion macros for the glow convolution block.
`ifndef GLOW_ALPHA_CONVOLUTION_5X5_TOP_ASSERT_SVH
`define GLOW_ALPHA_CONVOLUTION_5X5_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define GAC5_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define GAC5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

[hw/rtl/gac5_pkg.sv]
// Shared types, constants and helpers of the glow convolution block.
`default_nettype none
package gac5_pkg;

  localparam int XW        = 12;  // column width inside the block
  localparam int YW        = 12;  // row width inside the block
  localparam int HW        = 13;  // effective height width
  localparam int SLOT_W    = 3;   // row-slot index, 0..4
  localparam int ROWS_KEPT = 5;
  localparam int KDIM      = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // kernel in hundredths, [vertical offset + 2][horizontal offset + 2]
  localparam int unsigned KERNEL_H [KDIM][KDIM] = '{
    '{1, 12,  18, 12, 1},
    '{6, 44, 120, 44, 6},
    '{6, 54, 200, 54, 6},
    '{4, 24,  54, 24, 4},
    '{0,  2,   4,  2, 0}
  };

  typedef struct packed {
    logic [XW-1:0]     x0;
    logic [XW-1:0]     x1;
    logic [YW-1:0]     y0;
    logic [YW-1:0]     y1;
    logic [SLOT_W-1:0] y0_slot;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [XW-1:0]     col;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic busy;
    logic issue;
  } seq_stat_t;

  // rounded fixed-point coefficient
  function automatic int unsigned coef(input int r, input int c, input int frac);
    return ((KERNEL_H[r][c] << frac) + 50) / 100;
  endfunction

  // add two slot numbers modulo five, operands summing to less than ten
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd5) s = s - 4'd5;
    return s[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/gac5_front.sv]
// Front end: accepts pixels, tracks position, writes the row store, queues jobs.
`default_nettype none
module gac5_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      restart,
  input  wire logic [gac5_pkg::XW-1:0]   w,
  input  wire logic [gac5_pkg::HW-1:0]   h,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                pixel_value,
  input  wire logic                      back_pending,
  input  wire logic                      q_full,
  output logic                           push,
  output gac5_pkg::job_t                 job,
  output gac5_pkg::wr_t                  wr
);

  logic [gac5_pkg::XW-1:0]     col;
  logic [gac5_pkg::YW-1:0]     row;
  logic [gac5_pkg::SLOT_W-1:0] slot;

  logic [gac5_pkg::XW-1:0]     px, wm1;
  logic [gac5_pkg::YW-1:0]     py;
  logic [gac5_pkg::HW-1:0]     hm1;
  logic [gac5_pkg::SLOT_W-1:0] pslot;
  logic                        acc, hx, hy, end_row;
  logic [1:0]                  d;

  always_comb begin
    if (col >= w || {1'b0, row} >= h) begin
      px = '0;
      py = '0;
      pslot = '0;
    end else begin
      px = col;
      py = row;
      pslot = slot;
    end
    wm1 = w - 12'd1;
    hm1 = h - 13'd1;
    end_row = (px == wm1);

    // a row start waits until the back end holds no job
    in_stall = q_full || (px == '0 && back_pending);
    acc = in_valid && !in_stall;

    hx = 1'b1;
    if (end_row) begin
      job.x0 = (w >= 12'd3) ? w - 12'd3 : '0;
      job.x1 = wm1;
    end else if (px >= 12'd2) begin
      job.x0 = px - 12'd2;
      job.x1 = job.x0;
    end else begin
      job.x0 = '0;
      job.x1 = '0;
      hx = 1'b0;
    end

    hy = 1'b1;
    if ({1'b0, py} == hm1) begin
      job.y0 = (h >= 13'd3) ? gac5_pkg::YW'(h - 13'd3) : '0;
      job.y1 = gac5_pkg::YW'(hm1);
    end else if (py >= 12'd2) begin
      job.y0 = py - 12'd2;
      job.y1 = job.y0;
    end else begin
      job.y0 = '0;
      job.y1 = '0;
      hy = 1'b0;
    end
    d = 2'(py - job.y0);
    job.y0_slot = gac5_pkg::slot_add(pslot, 3'd5 - {1'b0, d});

    push = acc && hx && hy;
    wr.en = acc;
    wr.slot = pslot;
    wr.col = px;
    wr.data = pixel_value;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
      slot <= '0;
    end else if (acc) begin
      if (end_row) begin
        col <= '0;
        if ({1'b0, py} == hm1) begin
          row <= '0;
          slot <= '0;
        end else begin
          row <= py + 12'd1;
          slot <= gac5_pkg::slot_add(pslot, 3'd1);
        end
      end else begin
        col <= px + 12'd1;
        row <= py;
        slot <= pslot;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gac5_fifo.sv]
// Four-entry job queue between front and back end.
`default_nettype none
module gac5_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gac5_pkg::job_t push_data,
  input  wire logic           pop,
  output gac5_pkg::job_t      head,
  output logic                valid,
  output logic                full
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  gac5_pkg::job_t  entry [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [PW:0]     cnt;
  logic            do_pop;

  assign valid  = (cnt != '0);
  assign full   = (cnt == (PW+1)'(DEPTH));
  assign head   = entry[rp];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) entry[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gac5_back.sv]
// Back end: row store, column sequencer, sliding window and kernel pipeline.
`default_nettype none
module gac5_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_FRAC_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      restart,
  input  wire logic [gac5_pkg::XW-1:0]   w,
  input  wire logic [gac5_pkg::HW-1:0]   h,
  input  wire gac5_pkg::wr_t             wr,
  input  wire logic                      q_valid,
  input  wire gac5_pkg::job_t            q_head,
  output logic                           q_pop,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output logic [7:0]                     alpha,
  output logic [10:0]                    out_x,
  output logic [11:0]                    out_y,
  output logic                           last_of_run,
  output gac5_pkg::seq_stat_t            stat
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int SW  = COEF_FRAC_BITS + 12;
  localparam int CFW = COEF_FRAC_BITS + 2;
  localparam int XW  = gac5_pkg::XW;
  localparam int YW  = gac5_pkg::YW;
  localparam int SLW = gac5_pkg::SLOT_W;
  localparam int NR  = gac5_pkg::ROWS_KEPT;
  localparam int K   = gac5_pkg::KDIM;

  logic          adv;
  logic [AW-1:0] raddr;
  logic [7:0]    rd [NR];

  assign adv = !(out_valid && out_stall);

  // one bank per kept row; write from the front, read one column of all banks
  for (genvar b = 0; b < NR; b++) begin : g_bank
    logic [7:0] bank [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (wr.en && wr.slot == SLW'(b)) bank[AW'(wr.col)] <= wr.data;
      if (adv) rd[b] <= bank[raddr];
    end
  end

  // sequencer
  logic           busy, win_valid;
  logic [XW-1:0]  jx0, jx1, cx, win_x;
  logic [YW-1:0]  jy1, cy, win_y;
  logic [SLW-1:0] cslot;
  logic [2:0]     k;

  logic [XW-1:0]  a_x, a_x0, a_x1;
  logic [YW-1:0]  a_y, a_y1;
  logic [SLW-1:0] a_slot;
  logic           issue, slide, done_out, last, col_ok;
  logic [XW:0]    colp;
  logic [XW-1:0]  col;
  logic [K-1:0]   rmask;
  logic [YW:0]    trow;

  always_comb begin
    a_x    = busy ? cx : q_head.x0;
    a_x0   = busy ? jx0 : q_head.x0;
    a_x1   = busy ? jx1 : q_head.x1;
    a_y    = busy ? cy : q_head.y0;
    a_y1   = busy ? jy1 : q_head.y1;
    a_slot = busy ? cslot : q_head.y0_slot;
    issue  = adv && (busy || q_valid);
    q_pop  = adv && !busy && q_valid;
    slide  = (k == 3'd0) && win_valid && (a_y == win_y) &&
             ({1'b0, a_x} == {1'b0, win_x} + 13'd1);
    // colp is the tap column plus two
    colp   = {1'b0, a_x} + (slide ? 13'd4 : {10'd0, k});
    col    = XW'(colp - 13'd2);
    col_ok = (colp >= 13'd2) && (col < w);
    done_out = slide || (k == 3'd4);
    last   = (a_x == a_x1) && (a_y == a_y1);
    raddr  = AW'(col);
    for (int r = 0; r < K; r++) begin
      trow = {1'b0, a_y} + (YW+1)'(r);
      rmask[r] = (trow >= 13'd2) && ((trow - 13'd2) < h);
    end
    stat.busy  = busy;
    stat.issue = issue;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      jx0 <= q_head.x0;
      jx1 <= q_head.x1;
      jy1 <= q_head.y1;
    end
    if (issue) begin
      if (done_out) begin
        win_x <= a_x;
        win_y <= a_y;
        if (a_x == a_x1) begin
          cx <= a_x0;
          cy <= a_y + 12'd1;
          cslot <= gac5_pkg::slot_add(a_slot, 3'd1);
        end else begin
          cx <= a_x + 12'd1;
          cy <= a_y;
          cslot <= a_slot;
        end
      end else begin
        cx <= a_x;
        cy <= a_y;
        cslot <= a_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b0;
      k <= '0;
      win_valid <= 1'b0;
    end else if (issue) begin
      if (done_out) begin
        k <= '0;
        win_valid <= 1'b1;
        busy <= !last;
      end else begin
        k <= k + 3'd1;
        busy <= 1'b1;
      end
    end
  end

  // read stage tags
  logic           t_valid, t_col_ok, t_done, t_last;
  logic [XW-1:0]  t_x;
  logic [YW-1:0]  t_y;
  logic [SLW-1:0] t_base;
  logic [K-1:0]   t_rmask;

  always_ff @(posedge clk) begin
    if (rst) t_valid <= 1'b0;
    else if (adv) t_valid <= issue;
    if (adv) begin
      t_col_ok <= col_ok;
      t_done   <= done_out;
      t_last   <= last;
      t_x      <= a_x;
      t_y      <= a_y;
      t_base   <= gac5_pkg::slot_add(a_slot, 3'd3);
      t_rmask  <= rmask;
    end
  end

  // window shift and per-row products
  logic [7:0]    win_pix [K][K];
  logic [7:0]    shf [K][K];
  logic [SW-1:0] rsum [K];

  always_comb begin
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K - 1; c++) shf[r][c] = win_pix[r][c+1];
      shf[r][K-1] = (t_col_ok && t_rmask[r]) ?
                    rd[gac5_pkg::slot_add(t_base, SLW'(r))] : 8'd0;
    end
    for (int r = 0; r < K; r++) begin
      rsum[r] = '0;
      for (int c = 0; c < K; c++) begin
        rsum[r] = rsum[r] +
          SW'(CFW'(gac5_pkg::coef(r, c, COEF_FRAC_BITS))) * SW'(shf[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && t_valid) win_pix <= shf;
  end

  logic          s_valid, s_last;
  logic [XW-1:0] s_x;
  logic [YW-1:0] s_y;
  logic [SW-1:0] s_rsum [K];
  logic [SW-1:0] total, scaled;

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (adv) s_valid <= t_valid && t_done;
    if (adv) begin
      s_rsum <= rsum;
      s_x <= t_x;
      s_y <= t_y;
      s_last <= t_last;
    end
  end

  always_comb begin
    total = '0;
    for (int r = 0; r < K; r++) total = total + s_rsum[r];
    scaled = total >> COEF_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s_valid;
    if (adv) begin
      alpha <= (scaled > SW'(255)) ? 8'd255 : scaled[7:0];
      out_x <= s_x[10:0];
      out_y <= s_y;
      last_of_run <= s_last;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/glow_alpha_convolution_5x5_top.sv]
// Top level of the streaming 5x5 glow convolution filter.
`default_nettype none
// Streaming 5x5 glow filter. Coverage bytes enter in raster order, one per
// cycle unless stalled, and each produces the results whose bottom-right
// tap it completes (none, one, three at a row end or on the last row, up to
// nine at the frame end), each tagged with its column, row and a last-of-run
// flag. Results leave at one per cycle when consecutive outputs share a row
// and out_stall is low: the back end slides a 5-column window and reads one
// new column of the five-bank row store per result. The first result of a row
// reloads all five columns. At each row start the input stalls until the job
// queue and the column sequencer are empty, so the end-of-row burst drains
// before the next row overwrites the store. A result passes the read, row-sum
// and output registers. The row store needs no clearing: every tap inside the
// frame is written before it is read. Write frame_width or frame_height only
// while idle; either write restarts the frame at (0,0).
module glow_alpha_convolution_5x5_top #(
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_FRAC_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [gac5_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gac5_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       pixel_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            alpha,
  output logic [10:0]                           out_x,
  output logic [11:0]                           out_y,
  output logic                                  last_of_run
);

  logic [gac5_pkg::FW_W-1:0] frame_width;
  logic [gac5_pkg::FH_W-1:0] frame_height;
  logic [gac5_pkg::XW-1:0]   w_eff;
  logic [gac5_pkg::HW-1:0]   h_eff;
  logic                      restart;

  // only the two listed registers restart the frame; other indexes drop
  assign restart = cfg_write &&
                   (cfg_index == gac5_pkg::REG_FRAME_WIDTH ||
                    cfg_index == gac5_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd64;
      frame_height <= 13'd16;
    end else if (cfg_write) begin
      case (cfg_index)
        gac5_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[gac5_pkg::FW_W-1:0];
        gac5_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the frame: zero acts as one, width caps at the row store size, height at MAX_HEIGHT
  always_comb begin
    if (frame_width == '0)
      w_eff = 12'd1;
    else if ({2'b00, frame_width} > 14'(MAX_WIDTH))
      w_eff = 12'(MAX_WIDTH);
    else
      w_eff = frame_width;
    if (frame_height == '0)
      h_eff = 13'd1;
    else if (frame_height > 13'(gac5_pkg::MAX_HEIGHT))
      h_eff = 13'(gac5_pkg::MAX_HEIGHT);
    else
      h_eff = frame_height;
  end

  gac5_pkg::job_t      f_job, q_head;
  gac5_pkg::wr_t       wr;
  gac5_pkg::seq_stat_t seq_stat;
  logic                q_push, q_pop, q_valid, q_full, back_pending;

  // a job is outstanding while queued or while the sequencer still reads
  assign back_pending = q_valid || seq_stat.busy;

  gac5_front u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .w            (w_eff),
    .h            (h_eff),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_value  (pixel_value),
    .back_pending (back_pending),
    .q_full       (q_full),
    .push         (q_push),
    .job          (f_job),
    .wr           (wr)
  );

  gac5_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (f_job),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid),
    .full      (q_full)
  );

  gac5_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .w           (w_eff),
    .h           (h_eff),
    .wr          (wr),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .alpha       (alpha),
    .out_x       (out_x),
    .out_y       (out_y),
    .last_of_run (last_of_run),
    .stat        (seq_stat)
  );

`include "glow_alpha_convolution_5x5_top_assert.svh"

  // the queue never takes a job while full
  `GAC5_ASSERT_IMPLIES(a_fifo_no_overflow, q_push, !q_full)
  // the sequencer reads only on behalf of a held or queued job
  `GAC5_ASSERT_IMPLIES(a_issue_has_job, seq_stat.issue, seq_stat.busy || q_valid)
  // a restart leaves the sequencer idle
  `GAC5_ASSERT_NEXT(a_restart_idle, restart, !seq_stat.busy)

endmodule
`default_nettype wire
